>>> rtl/dnsc_pkg.sv
// dnsc_pkg: shared types, constants and helpers for the dns name checker
// no dependencies; imported by every module of the block

package dnsc_pkg;

  // name and label limits, and the counter widths that follow from them
  localparam int MAX_NAME_LEN  = 255;
  localparam int MAX_LABEL_LEN = 63;
  localparam int NAME_W        = $clog2(MAX_NAME_LEN + 2);
  localparam int LABEL_W       = $clog2(MAX_LABEL_LEN + 2);
  localparam logic [NAME_W-1:0]  NAME_LIMIT  = NAME_W'(MAX_NAME_LEN);
  localparam logic [LABEL_W-1:0] LABEL_LIMIT = LABEL_W'(MAX_LABEL_LEN);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // characters with a meaning of their own
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // verdict codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LONG   = 3'd1,
    ST_LONE       = 3'd2,
    ST_LEAD_DOT   = 3'd3,
    ST_BAD_CHAR   = 3'd4,
    ST_DOUBLE_DOT = 3'd5,
    ST_LABEL_LONG = 3'd6
  } dnsc_status_t;

  // one classified character on its way to the back end
  typedef struct packed {
    logic [7:0]   ch;
    logic         last;
    dnsc_status_t status;
    logic         append;
  } dnsc_job_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  // letters, digits, dash and underscore
  function automatic logic is_plain(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || is_upper(c) ||
           ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DASH) || (c == CH_USCORE);
  endfunction

endpackage

>>> rtl/dnsc_in_if.sv
// dnsc_in_if: request channel carrying one name character
// no dependencies

interface dnsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       allow_wildcard;
  logic       last_char;

  modport source (output valid, name_char, allow_wildcard, last_char, input ready);
  modport sink   (input valid, name_char, allow_wildcard, last_char, output ready);
endinterface

>>> rtl/dnsc_out_if.sv
// dnsc_out_if: result channel carrying one normalised character and verdict
// no dependencies

interface dnsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic [2:0] status;

  modport source (output valid, out_char, out_last, status, input ready);
  modport sink   (input valid, out_char, out_last, status, output ready);
endinterface

>>> rtl/dns_name_checker_core.sv
// channel    dir  payload                                  handshake
// name_req   in   name_char[7:0] allow_wildcard last_char  valid/ready
// result     out  out_char[7:0] out_last status[2:0]       valid/ready
//
// one request accepted per cycle while the queue has room; each is written into the queue,
// and its results are loaded into the result register once that register is free or taken
// a passing name not ending in a dot yields two results, so result rate of one per cycle
// while the sink is ready sets the pace when such names arrive back to back
// the four-entry queue lets the front keep taking requests while results stall
// synchronous reset clears name state, queue pointers and result valid; no clearing pass
// dns_name_checker_core: top level; depends on dnsc_pkg, interfaces, front, queue, back

module dns_name_checker_core
  import dnsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  dnsc_in_if.sink    name_req,
  dnsc_out_if.source result
);

  dnsc_job_t push_job;
  logic      push_valid;
  logic      push_ready;
  dnsc_job_t head_job;
  logic      head_valid;
  logic      pop;

  // classification
  dnsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .name_req  (name_req),
    .job       (push_job),
    .job_valid (push_valid),
    .job_ready (push_ready)
  );

  // decoupling queue
  dnsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // result generation
  dnsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

endmodule

>>> rtl/dnsc_front.sv
// dnsc_front: accepts characters, tracks name and label state, classifies
// depends on dnsc_pkg and dnsc_in_if

module dnsc_front
  import dnsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  dnsc_in_if.sink       name_req,
  output dnsc_job_t     job,
  output logic          job_valid,
  input  logic          job_ready
);

  logic [NAME_W-1:0]  char_count;
  logic [LABEL_W-1:0] label_length;
  logic               previous_was_dot;
  logic               star_pending;
  logic               first_was_dot;
  logic               wildcard_latched;
  dnsc_status_t       fault_code;

  logic [NAME_W-1:0]  char_count_next;
  logic [LABEL_W-1:0] label_length_next;
  logic               previous_was_dot_next;
  logic               star_pending_next;
  logic               first_was_dot_next;
  logic               wildcard_latched_next;
  dnsc_status_t       fault_code_next;

  logic               accept;
  logic               first;
  logic               is_dot;
  logic               wild_cur;
  logic               prev_dot_cur;
  dnsc_status_t       status;

  assign accept          = name_req.valid && job_ready;
  assign name_req.ready  = job_ready;
  assign job_valid       = name_req.valid;

  // per-character checks and state update
  always_comb begin
    first    = (char_count == '0);
    is_dot   = (name_req.name_char == CH_DOT);
    wild_cur = first ? name_req.allow_wildcard : wildcard_latched;
    prev_dot_cur = first ? 1'b0 : previous_was_dot;

    first_was_dot_next    = first ? is_dot : first_was_dot;
    wildcard_latched_next = wild_cur;
    label_length_next     = label_length;
    fault_code_next       = fault_code;
    star_pending_next     = 1'b0;
    previous_was_dot_next = 1'b0;

    // settle a star held over from the previous character
    if (star_pending) begin
      if (!is_dot) begin
        if (fault_code_next == ST_OK) fault_code_next = ST_BAD_CHAR;
      end else begin
        if (label_length_next <= LABEL_LIMIT) label_length_next = label_length_next + 1'b1;
        if ((label_length_next > LABEL_LIMIT) && (fault_code_next == ST_OK))
          fault_code_next = ST_LABEL_LONG;
      end
    end

    // classify this character
    if ((name_req.name_char == CH_STAR) && wild_cur && !name_req.last_char) begin
      star_pending_next = 1'b1;
    end else if (is_dot) begin
      if (prev_dot_cur && (fault_code_next == ST_OK)) fault_code_next = ST_DOUBLE_DOT;
      label_length_next     = '0;
      previous_was_dot_next = 1'b1;
    end else if (is_plain(name_req.name_char)) begin
      if (label_length_next <= LABEL_LIMIT) label_length_next = label_length_next + 1'b1;
      if ((label_length_next > LABEL_LIMIT) && (fault_code_next == ST_OK))
        fault_code_next = ST_LABEL_LONG;
    end else begin
      if (fault_code_next == ST_OK) fault_code_next = ST_BAD_CHAR;
    end

    char_count_next = (char_count <= NAME_LIMIT) ? char_count + 1'b1 : char_count;
  end

  // verdict for the name, taken on its final character
  always_comb begin
    if (char_count_next > NAME_LIMIT)
      status = ST_TOO_LONG;
    else if ((char_count_next == NAME_W'(1)) && !is_dot)
      status = ST_LONE;
    else if ((char_count_next > NAME_W'(1)) && first_was_dot_next)
      status = ST_LEAD_DOT;
    else
      status = fault_code_next;
  end

  // job for the back end
  always_comb begin
    job.ch     = is_upper(name_req.name_char) ? (name_req.name_char | 8'h20)
                                              : name_req.name_char;
    job.last   = name_req.last_char;
    job.status = name_req.last_char ? status : ST_OK;
    job.append = name_req.last_char && (status == ST_OK) && !is_dot;
  end

  // state registers, back to reset after each final character
  always_ff @(posedge clk) begin
    if (rst || (accept && name_req.last_char)) begin
      char_count       <= '0;
      label_length     <= '0;
      previous_was_dot <= 1'b0;
      star_pending     <= 1'b0;
      first_was_dot    <= 1'b0;
      wildcard_latched <= 1'b0;
      fault_code       <= ST_OK;
    end else if (accept) begin
      char_count       <= char_count_next;
      label_length     <= label_length_next;
      previous_was_dot <= previous_was_dot_next;
      star_pending     <= star_pending_next;
      first_was_dot    <= first_was_dot_next;
      wildcard_latched <= wildcard_latched_next;
      fault_code       <= fault_code_next;
    end
  end

  // a held star always follows at least one character of the same name
  a_star_not_first: assert property (@(posedge clk) disable iff (rst)
    star_pending |-> (char_count != '0))
    else $error("star pending at start of name");

  // label counter saturates one past the limit
  a_label_sat: assert property (@(posedge clk) disable iff (rst)
    label_length <= LABEL_LIMIT + 1'b1)
    else $error("label length beyond saturation");

  // counters restart after a final character
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && name_req.last_char) |=> ((char_count == '0) && (fault_code == ST_OK)))
    else $error("state not cleared after final character");

endmodule

>>> rtl/dnsc_queue.sv
// dnsc_queue: short first-in first-out queue of classified characters
// depends on dnsc_pkg

module dnsc_queue
  import dnsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dnsc_job_t push_job,
  input  logic      push_valid,
  output logic      push_ready,
  output dnsc_job_t head_job,
  output logic      head_valid,
  input  logic      pop
);

  dnsc_job_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               push;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];
  assign push       = push_valid && push_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill != QCNT_W'(QUEUE_DEPTH)) |-> (QPTR_W'(wr_ptr - rd_ptr) == fill[QPTR_W-1:0]))
    else $error("queue pointers disagree with fill level");

endmodule

>>> rtl/dnsc_back.sv
// dnsc_back: drains the queue into the result register, adding the trailing dot
// depends on dnsc_pkg and dnsc_out_if

module dnsc_back
  import dnsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dnsc_job_t head_job,
  input  logic      head_valid,
  output logic      pop,
  dnsc_out_if.source result
);

  logic         out_valid;
  logic [7:0]   out_char;
  logic         out_last;
  dnsc_status_t out_status;
  logic         phase;
  logic         load;

  assign load = head_valid && (!out_valid || result.ready);
  // a job needing a dot leaves the queue only with its second result
  assign pop  = load && (!head_job.append || phase);

  assign result.valid    = out_valid;
  assign result.out_char = out_char;
  assign result.out_last = out_last;
  assign result.status   = out_status;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      phase     <= head_job.append && !phase;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (phase) begin
        out_char   <= CH_DOT;
        out_last   <= 1'b1;
        out_status <= ST_OK;
      end else if (head_job.append) begin
        out_char   <= head_job.ch;
        out_last   <= 1'b0;
        out_status <= ST_OK;
      end else begin
        out_char   <= head_job.ch;
        out_last   <= head_job.last;
        out_status <= head_job.status;
      end
    end
  end

  // while the dot is owed, the register holds the plain echo of the last char
  a_phase_echo: assert property (@(posedge clk) disable iff (rst)
    phase |-> (out_valid && !out_last && (out_status == ST_OK)))
    else $error("owed dot without matching echo");

  a_dot_follows: assert property (@(posedge clk) disable iff (rst)
    (load && phase) |=> (out_valid && out_last && (out_char == CH_DOT)))
    else $error("trailing dot not emitted");

  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_status == ST_OK))
    else $error("verdict on a non-final result");

endmodule
